// ===== rtl/cmf_pkg.sv =====
package cmf_pkg;

  localparam int LBL_W    = 8;
  localparam int NC_W     = 5;
  localparam int QW       = 17;
  localparam int FRAC     = 16;
  localparam int IN_W     = 2 * LBL_W;
  localparam int OUT_W    = 56;
  localparam logic [NC_W-1:0] NC_RESET = 5'd16;

  typedef struct packed {
    logic rd;
    logic clr;
  } cmf_mem_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmf_unit_stat_t;

endpackage

// ===== rtl/cmf_count.sv =====
module cmf_count
  import cmf_pkg::*;
#(
  parameter int CW = 16,
  parameter int LW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              inc_vld,
  input  logic [2*LW-1:0]   inc_addr,
  input  cmf_mem_cmd_t      cmd,
  input  logic [2*LW-1:0]   cmd_addr,
  output logic [CW-1:0]     rd_data
);

  localparam int AW    = 2 * LW;
  localparam int DEPTH = 1 << AW;

  logic [CW-1:0] mem_r [DEPTH];
  logic [CW-1:0] rd_q_r;
  logic          b_vld_r;
  logic [AW-1:0] b_addr_r;
  logic          wb_vld_r;
  logic [AW-1:0] wb_addr_r;
  logic [CW-1:0] wb_data_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic [CW-1:0] old_val;
  logic [CW-1:0] sat_val;

  assign rd_en   = cmd.rd | inc_vld;
  assign rd_addr = cmd.rd ? cmd_addr : inc_addr;

  // The previous increment may target the same counter; its value is not yet readable.
  assign old_val = (wb_vld_r && (wb_addr_r == b_addr_r)) ? wb_data_r : rd_q_r;
  assign sat_val = (&old_val) ? old_val : old_val + 1'b1;

  assign wr_en   = cmd.clr | b_vld_r;
  assign wr_addr = cmd.clr ? cmd_addr : b_addr_r;
  assign wr_data = cmd.clr ? '0 : sat_val;

  assign rd_data = rd_q_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r  <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      b_vld_r  <= inc_vld;
      wb_vld_r <= b_vld_r;
    end
    b_addr_r  <= inc_addr;
    wb_addr_r <= b_addr_r;
    wb_data_r <= sat_val;
  end

  a_no_clr_during_inc: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr && b_vld_r))
    else $error("clear sweep collides with a counter update");

  a_no_sweep_rd_during_inc: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && (inc_vld || b_vld_r)))
    else $error("metric read overlaps a pending counter update");

  a_no_rd_during_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && cmd.clr))
    else $error("metric read issued during clear sweep");

endmodule

// ===== rtl/cmf_div.sv =====
module cmf_div
  import cmf_pkg::*;
#(
  parameter int DW = 34,
  parameter int VW = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [VW-1:0]  divisor,
  output cmf_unit_stat_t stat,
  output logic [DW-1:0]  quotient
);

  localparam int CNTW = $clog2(DW);

  logic [DW-1:0]   dq_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [VW:0]     shifted;
  logic            ge;
  logic [VW-1:0]   rem_nxt;

  assign shifted = {rem_r, dq_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign rem_nxt = ge ? VW'(shifted - {1'b0, dvs_r}) : VW'(shifted);

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNTW'(DW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== rtl/cmf_mul.sv =====
module cmf_mul
  import cmf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [QW-1:0]   a,
  input  logic [QW-1:0]   b,
  output cmf_unit_stat_t  stat,
  output logic [2*QW-1:0] product
);

  localparam int PRW  = 2 * QW;
  localparam int CNTW = $clog2(QW);

  logic [PRW-1:0]  mcand_r;
  logic [QW-1:0]   mplier_r;
  logic [PRW-1:0]  acc_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNTW'(QW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(QW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
    if (start) begin
      mcand_r  <= PRW'(a);
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[PRW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[QW-1:1]};
    end
  end

endmodule

// ===== rtl/confusion_matrix_macro_f_measure.sv =====
// Label pairs are taken one per cycle while idle; each in-range pair is a read-modify-write
// of one counter word. A last pair starts one result, computed with a bit-serial divider
// shared by all ratios, of DW = max(COUNT_WIDTH + 16, 34, QW + clog2(MAX_CLASSES)) bits.
// After each result, and after reset, all 4**clog2(MAX_CLASSES) counter words (256 by default)
// are swept to zero, during which no pair is accepted.
// Reset (rst_n low, synchronous) clears control state and sets num_classes to 16.
module confusion_matrix_macro_f_measure
  import cmf_pkg::*;
#(
  parameter int MAX_CLASSES = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [NC_W-1:0]  cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // detected_label, true_label
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // precision_avg, recall_avg, f_measure, label_error
);

  localparam int LW    = $clog2(MAX_CLASSES);
  localparam int AW    = 2 * LW;
  localparam int NW    = $clog2(MAX_CLASSES + 1);
  localparam int SW    = COUNT_WIDTH + LW;
  localparam int PW    = QW + LW;
  localparam int DW_A  = (COUNT_WIDTH + FRAC > 2 * QW) ? COUNT_WIDTH + FRAC : 2 * QW;
  localparam int DW    = (DW_A > PW) ? DW_A : PW;
  localparam int VW    = (SW > QW + 1) ? SW : QW + 1;
  localparam int LBW1  = LBL_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_ROW, S_COL, S_DIVP, S_DIVR,
    S_AVGP, S_AVGR, S_MUL, S_DIVF, S_EMIT
  } state_t;

  state_t               state_r;
  logic [NC_W-1:0]      cfg_num_r;
  logic                 err_r;
  logic                 err_final_r;
  logic [AW-1:0]        clr_r;
  logic [LW-1:0]        cls_r;
  logic [LW-1:0]        j_r;
  logic                 tag_vld_r;
  logic                 tag_col_r;
  logic                 tag_diag_r;
  logic [SW-1:0]        row_r;
  logic [SW-1:0]        col_r;
  logic [COUNT_WIDTH-1:0] diag_r;
  logic [PW-1:0]        psum_r;
  logic [PW-1:0]        rsum_r;
  logic [QW-1:0]        p_r;
  logic [QW-1:0]        r_r;
  logic [2*QW-1:0]      prod_r;
  logic                 div_start_r;
  logic                 mul_start_r;
  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  logic [NW-1:0]        n_eff;
  logic [LW-1:0]        n_last;
  logic [LBL_W-1:0]     det;
  logic [LBL_W-1:0]     tru;
  logic                 in_rng;
  logic                 acc;
  logic [AW-1:0]        inc_addr;
  cmf_mem_cmd_t         cmd;
  logic [AW-1:0]        cmd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [DW-1:0]        dvd;
  logic [VW-1:0]        dvs;
  cmf_unit_stat_t       div_stat;
  logic [DW-1:0]        quo;
  cmf_unit_stat_t       mul_stat;
  logic [2*QW-1:0]      product;
  logic [QW:0]          pr_sum;
  logic [QW-1:0]        ratio_p;
  logic [QW-1:0]        ratio_r;
  logic                 div_start_nxt;
  logic                 mul_start_nxt;

  always_comb begin
    if (cfg_num_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_num_r) > MAX_CLASSES) begin
      n_eff = NW'(MAX_CLASSES);
    end else begin
      n_eff = NW'(cfg_num_r);
    end
  end

  assign n_last   = LW'(n_eff - NW'(1));
  assign det      = in_tdata[LBL_W-1:0];
  assign tru      = in_tdata[IN_W-1:LBL_W];
  assign in_rng   = (det != '0) && (tru != '0) &&
                    (LBW1'(det) <= LBW1'(n_eff)) && (LBW1'(tru) <= LBW1'(n_eff));
  assign in_tready = (state_r == S_IDLE);
  assign acc      = in_tvalid && in_tready;
  assign inc_addr = {LW'(det - 1'b1), LW'(tru - 1'b1)};

  assign cmd.rd   = (state_r == S_ROW) || (state_r == S_COL);
  assign cmd.clr  = (state_r == S_CLEAR);
  always_comb begin
    unique case (state_r)
      S_ROW:   cmd_addr = {cls_r, j_r};
      S_COL:   cmd_addr = {j_r, cls_r};
      default: cmd_addr = clr_r;
    endcase
  end

  assign pr_sum  = {1'b0, p_r} + {1'b0, r_r};
  assign ratio_p = (row_r == '0) ? '0 : quo[QW-1:0];
  assign ratio_r = (col_r == '0) ? '0 : quo[QW-1:0];

  assign div_start_nxt = ((state_r == S_COL) && (j_r == n_last)) ||
                         (((state_r == S_DIVP) || (state_r == S_AVGP)) && div_stat.done) ||
                         ((state_r == S_DIVR) && div_stat.done && (cls_r == n_last)) ||
                         ((state_r == S_MUL) && mul_stat.done);
  assign mul_start_nxt = (state_r == S_AVGR) && div_stat.done;

  always_comb begin
    unique case (state_r)
      S_DIVP: begin
        dvd = DW'({diag_r, {FRAC{1'b0}}});
        dvs = VW'(row_r);
      end
      S_DIVR: begin
        dvd = DW'({diag_r, {FRAC{1'b0}}});
        dvs = VW'(col_r);
      end
      S_AVGP: begin
        dvd = DW'(psum_r);
        dvs = VW'(n_eff);
      end
      S_AVGR: begin
        dvd = DW'(rsum_r);
        dvs = VW'(n_eff);
      end
      default: begin
        dvd = DW'({prod_r[2*QW-2:0], 1'b0});
        dvs = VW'(pr_sum);
      end
    endcase
  end

  cmf_count #(
    .CW (COUNT_WIDTH),
    .LW (LW)
  ) u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .inc_vld  (acc && in_rng),
    .inc_addr (inc_addr),
    .cmd      (cmd),
    .cmd_addr (cmd_addr),
    .rd_data  (rd_data)
  );

  cmf_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dvd),
    .divisor  (dvs),
    .stat     (div_stat),
    .quotient (quo)
  );

  cmf_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (p_r),
    .b       (r_r),
    .stat    (mul_stat),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cfg_num_r    <= NC_RESET;
      err_r        <= 1'b0;
      clr_r        <= '0;
      tag_vld_r    <= 1'b0;
      div_start_r  <= 1'b0;
      mul_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      div_start_r <= div_start_nxt;
      mul_start_r <= mul_start_nxt;
      tag_vld_r   <= cmd.rd;
      if (cfg_wr_en) begin
        cfg_num_r <= cfg_wr_data;
      end
      if ((state_r == S_EMIT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (in_tlast) begin
              err_final_r <= err_r | !in_rng;
              err_r       <= 1'b0;
              state_r     <= S_START;
            end else if (!in_rng) begin
              err_r <= 1'b1;
            end
          end
        end
        S_START: begin
          state_r <= S_ROW;
        end
        S_ROW: begin
          if (j_r == n_last) begin
            j_r     <= '0;
            state_r <= S_COL;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_COL: begin
          if (j_r == n_last) begin
            j_r     <= '0;
            state_r <= S_DIVP;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DIVP: begin
          if (div_stat.done) begin
            psum_r  <= psum_r + PW'(ratio_p);
            state_r <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_stat.done) begin
            rsum_r <= rsum_r + PW'(ratio_r);
            if (cls_r == n_last) begin
              state_r <= S_AVGP;
            end else begin
              cls_r   <= cls_r + 1'b1;
              state_r <= S_ROW;
            end
          end
        end
        S_AVGP: begin
          if (div_stat.done) begin
            p_r     <= quo[QW-1:0];
            state_r <= S_AVGR;
          end
        end
        S_AVGR: begin
          if (div_stat.done) begin
            r_r     <= quo[QW-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            prod_r  <= product;
            state_r <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (div_stat.done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r <= {{(OUT_W - 3 * QW - 1){1'b0}}, err_final_r,
                            (pr_sum == '0) ? {QW{1'b0}} : quo[QW-1:0], r_r, p_r};
            clr_r       <= '0;
            state_r     <= S_CLEAR;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
    if (acc && in_tlast) begin
      cls_r  <= '0;
      j_r    <= '0;
      psum_r <= '0;
      rsum_r <= '0;
    end
    if ((acc && in_tlast) || ((state_r == S_DIVR) && div_stat.done)) begin
      row_r  <= '0;
      col_r  <= '0;
      diag_r <= '0;
    end else if (tag_vld_r) begin
      if (tag_col_r) begin
        col_r <= col_r + SW'(rd_data);
      end else begin
        row_r <= row_r + SW'(rd_data);
      end
      if (tag_diag_r) begin
        diag_r <= rd_data;
      end
    end
    tag_col_r  <= (state_r == S_COL);
    tag_diag_r <= (state_r == S_ROW) && (j_r == cls_r);
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (div_start_r || mul_start_r) |-> !(div_stat.busy || mul_stat.busy))
    else $error("arithmetic unit started while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata_r)))
    else $error("result word changed while waiting");

  a_out_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[OUT_W-1:3*QW+1] == '0))
    else $error("result word padding is not zero");

endmodule

// ===== verif/tb_confusion_matrix_macro_f_measure.sv =====
`timescale 1ns / 1ps

module tb_confusion_matrix_macro_f_measure;
  import cmf_pkg::*;

  localparam int MAX_CLASSES = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int SETTLE_CYCLES = 2500;
  localparam int HOLD_CYCLES = 4000;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int RANDOM_PAIRS = 1620;

  typedef struct packed {
    logic [QW-1:0] prec;
    logic [QW-1:0] rec;
    logic [QW-1:0] fm;
    logic          err;
  } score_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [NC_W-1:0]  cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;    // detected_label, true_label
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // precision_avg, recall_avg, f_measure, label_error

  logic [COUNT_WIDTH-1:0] tally [MAX_CLASSES][MAX_CLASSES];
  logic                   label_err_seen;
  logic [NC_W-1:0]        class_reg;
  score_t                 pending_scores [$];

  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit rx_hold_req = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  confusion_matrix_macro_f_measure #(
    .MAX_CLASSES(MAX_CLASSES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic int unsigned classes_in_use();
    if (class_reg == 0) return 1;
    if (class_reg > MAX_CLASSES) return MAX_CLASSES;
    return int'(class_reg);
  endfunction

  function automatic longint unsigned q16_ratio(input longint unsigned part,
                                                input longint unsigned whole);
    if (whole == 0) return 0;
    return (part << FRAC) / whole;
  endfunction

  function automatic void clear_tally();
    foreach (tally[i, j]) tally[i][j] = '0;
    label_err_seen = 1'b0;
  endfunction

  function automatic void tally_pair(input logic [LBL_W-1:0] det,
                                     input logic [LBL_W-1:0] tru, input logic last);
    int unsigned       n;
    longint unsigned   row_sum, col_sum, prec_sum, rec_sum, p, r, f;
    score_t            s;
    n = classes_in_use();
    if (det >= 1 && det <= n && tru >= 1 && tru <= n) begin
      if (tally[det-1][tru-1] != '1) tally[det-1][tru-1]++;
    end else begin
      label_err_seen = 1'b1;
    end
    if (!last) return;
    prec_sum = 0;
    rec_sum = 0;
    for (int i = 0; i < n; i++) begin
      row_sum = 0;
      col_sum = 0;
      for (int j = 0; j < n; j++) begin
        row_sum += tally[i][j];
        col_sum += tally[j][i];
      end
      prec_sum += q16_ratio(tally[i][i], row_sum);
      rec_sum += q16_ratio(tally[i][i], col_sum);
    end
    p = prec_sum / n;
    r = rec_sum / n;
    f = (p + r == 0) ? 0 : (2 * p * r) / (p + r);
    s.prec = p[QW-1:0];
    s.rec = r[QW-1:0];
    s.fm = f[QW-1:0];
    s.err = label_err_seen;
    pending_scores.push_back(s);
    clear_tally();
  endfunction

  task automatic send_pair(input logic [LBL_W-1:0] det, input logic [LBL_W-1:0] tru,
                           input logic last);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tru, det};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    tally_pair(det, tru, last);
  endtask

  task automatic end_phase();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_class_count(input logic [NC_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    class_reg = value;
    @(posedge clk);
  endtask

  function automatic logic [LBL_W-1:0] pick_label(input int unsigned n);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 88) return LBL_W'($urandom_range(1, n));
    if (roll < 92) return '0;
    if (roll < 96) return LBL_W'($urandom_range(n + 1, 255));
    return LBL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [NC_W-1:0] pick_class_setting();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      4: return NC_W'($urandom_range(0, 31));
      default: return NC_W'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic test_default_classes();
    send_pair(8'd1, 8'd1, 1'b0);
    send_pair(8'd2, 8'd2, 1'b0);
    send_pair(8'd16, 8'd16, 1'b0);
    send_pair(8'd16, 8'd1, 1'b0);
    send_pair(8'd1, 8'd16, 1'b0);
    send_pair(8'd8, 8'd3, 1'b0);
    send_pair(8'd5, 8'd5, 1'b1);
    send_pair(8'd0, 8'd0, 1'b1);
    send_pair(8'd255, 8'd255, 1'b1);
    send_pair(8'd3, 8'd3, 1'b0);
    send_pair(8'd17, 8'd1, 1'b1);
    end_phase();
  endtask

  task automatic test_class_count_limits();
    write_class_count(5'd0);
    send_pair(8'd1, 8'd1, 1'b0);
    send_pair(8'd1, 8'd1, 1'b1);
    send_pair(8'd2, 8'd1, 1'b1);
    end_phase();
    write_class_count(5'd31);
    send_pair(8'd16, 8'd16, 1'b0);
    send_pair(8'd17, 8'd17, 1'b1);
    end_phase();
    write_class_count(5'd17);
    send_pair(8'd3, 8'd3, 1'b0);
    send_pair(8'd16, 8'd2, 1'b1);
    end_phase();
    write_class_count(5'd1);
    send_pair(8'd1, 8'd1, 1'b0);
    send_pair(8'd0, 8'd1, 1'b1);
    end_phase();
  endtask

  task automatic test_perfect_and_confused();
    write_class_count(5'd4);
    for (int k = 1; k <= 4; k++) send_pair(k[LBL_W-1:0], k[LBL_W-1:0], k == 4);
    for (int k = 1; k <= 4; k++) send_pair(k[LBL_W-1:0], LBL_W'(k % 4 + 1), k == 4);
    end_phase();
  endtask

  task automatic test_class_change_mid_batch();
    write_class_count(5'd16);
    send_pair(8'd12, 8'd12, 1'b0);
    send_pair(8'd16, 8'd3, 1'b0);
    send_pair(8'd2, 8'd2, 1'b0);
    send_pair(8'd3, 8'd1, 1'b0);
    end_phase();
    write_class_count(5'd3);
    send_pair(8'd3, 8'd3, 1'b0);
    send_pair(8'd5, 8'd1, 1'b0);
    send_pair(8'd1, 8'd1, 1'b1);
    send_pair(8'd2, 8'd2, 1'b0);
    end_phase();
    write_class_count(5'd16);
    send_pair(8'd14, 8'd14, 1'b1);
    end_phase();
  endtask

  task automatic test_output_backpressure();
    int unsigned n;
    logic [LBL_W-1:0] tru;
    write_class_count(5'd8);
    n = classes_in_use();
    tx_gaps_on = 1'b0;
    rx_hold_req = 1'b1;
    for (int k = 1; k <= 40; k++) begin
      tru = LBL_W'($urandom_range(1, n));
      send_pair($urandom_range(0, 1) ? tru : LBL_W'($urandom_range(1, n)), tru, k % 10 == 0);
    end
    end_phase();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_batches();
    int sent;
    int batches;
    int len;
    int unsigned n;
    logic [LBL_W-1:0] tru;
    logic [LBL_W-1:0] det;
    sent = 0;
    batches = 0;
    while (sent < RANDOM_PAIRS) begin
      if (batches % 6 == 0) begin
        end_phase();
        write_class_count(pick_class_setting());
      end
      tx_gaps_on = $urandom_range(0, 3) != 0;
      rx_gaps_on = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 30);
      n = classes_in_use();
      for (int k = 1; k <= len; k++) begin
        tru = pick_label(n);
        det = $urandom_range(0, 1) ? tru : pick_label(n);
        send_pair(det, tru, k == len);
      end
      sent += len;
      batches++;
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    end_phase();
  endtask

  initial begin : receiver
    int unsigned wait_n;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_n = rx_gaps_on ? $urandom_range(0, 17) : 0;
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_tvalid || rx_hold_req) break;
      end
    end
  end

  always @(posedge clk) begin : score_check
    score_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch($sformatf("word %h with no score expected", out_tdata));
      end else begin
        want = pending_scores.pop_front();
        if (out_tdata[QW-1:0] !== want.prec)
          report_mismatch($sformatf("precision %0d, expected %0d",
                                    out_tdata[QW-1:0], want.prec));
        if (out_tdata[2*QW-1:QW] !== want.rec)
          report_mismatch($sformatf("recall %0d, expected %0d",
                                    out_tdata[2*QW-1:QW], want.rec));
        if (out_tdata[3*QW-1:2*QW] !== want.fm)
          report_mismatch($sformatf("f-measure %0d, expected %0d",
                                    out_tdata[3*QW-1:2*QW], want.fm));
        if (out_tdata[3*QW] !== want.err)
          report_mismatch($sformatf("label error %0b, expected %0b",
                                    out_tdata[3*QW], want.err));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    class_reg = NC_RESET;
    clear_tally();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_classes();
    test_class_count_limits();
    test_perfect_and_confused();
    test_class_change_mid_batch();
    test_output_backpressure();
    test_random_batches();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cmf_pkg.sv
rtl/cmf_count.sv
rtl/cmf_div.sv
rtl/cmf_mul.sv
rtl/confusion_matrix_macro_f_measure.sv
verif/tb_confusion_matrix_macro_f_measure.sv
